// ===== src/line_segment_window_clipper_core_defines.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared by the clipper rtl files
// ---------------------------------------------------------------------------
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_CORE_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LSWC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define LSWC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define LSWC_ASSERT(lbl, clk, rst_n, prop)
`define LSWC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== src/lswc_pkg.sv =====
// ---------------------------------------------------------------------------
// lswc_pkg
// shared widths and constants of the line clipper
// ---------------------------------------------------------------------------
package lswc_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CoordFracBits = 12;
  localparam int unsigned ParamFracBits = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_e;
endpackage

// ===== src/lswc_divider.sv =====
// ---------------------------------------------------------------------------
// lswc_divider
// pipelined restoring divider, one quotient bit per stage, with sign fixup
// ---------------------------------------------------------------------------
`include "line_segment_window_clipper_core_defines.svh"
module lswc_divider #(
  parameter int unsigned NumW  = 17,
  parameter int unsigned FracW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic signed [NumW-1:0]  num_i,
  input  logic signed [NumW-1:0]  den_i,
  output logic signed [NumW+FracW+1:0] quot_o
);
  // dividend magnitude is NumW+FracW bits wide at most
  localparam int unsigned QW = NumW + FracW;
  localparam int unsigned DW = NumW;

  logic [QW-1:0] rem_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          neg_q [QW+1];
  logic          fin_neg_q;
  logic [QW:0]   fin_q;

  logic [DW-1:0] num_mag;
  logic [DW-1:0] den_mag;

  assign num_mag = num_i[NumW-1] ? DW'(-num_i) : DW'(num_i);
  assign den_mag = den_i[NumW-1] ? DW'(-den_i) : DW'(den_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= QW'(num_mag) << FracW;
      den_q[0] <= den_mag;
      neg_q[0] <= (num_i[NumW-1] != den_i[NumW-1]) && (num_i != '0);
    end
  end

  // each stage shifts one dividend bit into the remainder
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [QW:0] trial;
    logic [QW-1:0] shifted;
    assign shifted = {rem_q[s][QW-2:0], quo_q[s][QW-1]};
    assign trial = {1'b0, shifted} - {{(QW+1-DW){1'b0}}, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1] <= trial[QW] ? shifted : trial[QW-1:0];
        quo_q[s+1] <= {quo_q[s][QW-2:0], ~trial[QW]};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // round toward minus infinity for a negative ratio
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fin_neg_q <= neg_q[QW];
      fin_q     <= {1'b0, quo_q[QW]} + {{QW{1'b0}}, (neg_q[QW] && rem_q[QW] != '0)};
    end
  end

  assign quot_o = fin_neg_q ? -$signed({1'b0, fin_q}) : $signed({1'b0, fin_q});

  `LSWC_ASSERT(a_rem_lt_den, clk_i, rst_ni, (den_q[QW] != '0) |-> (rem_q[QW] < QW'(den_q[QW])))
endmodule

// ===== src/line_segment_window_clipper_core.sv =====
// ---------------------------------------------------------------------------
// line_segment_window_clipper_core
// liang-barsky clipping of one segment per unstalled cycle vs a config window
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o carry one segment word (start and
//   end points, signed q4.12); accepted when valid is high and stall low
//   output channel: out_valid_o / out_stall_i carry the visible flag and the
//   clipped endpoints; a rejected segment gives visible 0 and zero points
//   config channel: cfg_valid_i / cfg_ready_o, index and 16-bit data, always
//   ready; user must change window registers only while pipe empty; unchecked
// throughput and depth
//   one word per cycle while not stalled; 1 + (17 + PARAM_FRAC_BITS + 2) + 3
//   register stages, the middle term set by the bit-per-stage dividers for
//   the four ratios
// stall
//   the whole pipe advances together; when the output word is held by a
//   stall, the input is stalled only if the last stage is occupied
// reset
//   valid bits clear, window goes to left/bottom 0 and right/top 1.0
// ---------------------------------------------------------------------------
`include "line_segment_window_clipper_core_defines.svh"
module line_segment_window_clipper_core #(
  parameter int unsigned COORD_FRAC_BITS = lswc_pkg::CoordFracBits,
  parameter int unsigned PARAM_FRAC_BITS = lswc_pkg::ParamFracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lswc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lswc_pkg::CoordW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [lswc_pkg::CoordW-1:0] start_x_i,
  input  logic signed [lswc_pkg::CoordW-1:0] start_y_i,
  input  logic signed [lswc_pkg::CoordW-1:0] end_x_i,
  input  logic signed [lswc_pkg::CoordW-1:0] end_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       visible_o,
  output logic signed [lswc_pkg::CoordW-1:0] clip_start_x_o,
  output logic signed [lswc_pkg::CoordW-1:0] clip_start_y_o,
  output logic signed [lswc_pkg::CoordW-1:0] clip_end_x_o,
  output logic signed [lswc_pkg::CoordW-1:0] clip_end_y_o
);
  localparam int unsigned CW = lswc_pkg::CoordW;
  localparam int unsigned DW = CW + 1;              // differences, p and q
  localparam int unsigned TW = DW + PARAM_FRAC_BITS + 2; // signed ratio
  localparam int unsigned DivLat = DW + PARAM_FRAC_BITS + 2;
  localparam int unsigned Depth = 1 + DivLat + 3;
  localparam int unsigned SW = PARAM_FRAC_BITS + 2; // entry/exit, 0 to 1.0
  localparam int unsigned PW = SW + DW;             // t * d product
  localparam logic signed [TW-1:0] OneT = TW'(1) <<< PARAM_FRAC_BITS;
  localparam logic signed [CW-1:0] OneC = CW'(1) <<< COORD_FRAC_BITS;

  // window registers
  logic signed [CW-1:0] left_q, right_q, bottom_q, top_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0; right_q <= OneC; bottom_q <= '0; top_q <= OneC;
    end else if (cfg_valid_i) begin
      unique case (lswc_pkg::reg_idx_e'(cfg_index_i))
        lswc_pkg::REG_LEFT:   left_q   <= cfg_data_i;
        lswc_pkg::REG_RIGHT:  right_q  <= cfg_data_i;
        lswc_pkg::REG_BOTTOM: bottom_q <= cfg_data_i;
        lswc_pkg::REG_TOP:    top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless a held output blocks it
  logic adv;
  logic [Depth-1:0] vld_q;
  assign adv = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  // stage 1: differences and boundary terms
  logic signed [DW-1:0] p_q [4];
  logic signed [DW-1:0] q_q [4];
  logic signed [CW-1:0] x1_q, y1_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [DW-1:0] dx, dy;
  assign dx = DW'(end_x_i) - DW'(start_x_i);
  assign dy = DW'(end_y_i) - DW'(start_y_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= -dx; q_q[0] <= DW'(start_x_i) - DW'(left_q);
      p_q[1] <= dx;  q_q[1] <= DW'(right_q) - DW'(start_x_i);
      p_q[2] <= -dy; q_q[2] <= DW'(start_y_i) - DW'(bottom_q);
      p_q[3] <= dy;  q_q[3] <= DW'(top_q) - DW'(start_y_i);
      x1_q <= start_x_i; y1_q <= start_y_i; dx_q <= dx; dy_q <= dy;
    end
  end

  // delay lines for side data across the dividers
  logic signed [CW-1:0] x1_d [DivLat+1];
  logic signed [CW-1:0] y1_d [DivLat+1];
  logic signed [DW-1:0] dx_d [DivLat+1];
  logic signed [DW-1:0] dy_d [DivLat+1];
  logic [3:0] pz_d [DivLat+1];
  logic [3:0] pn_d [DivLat+1];
  logic [3:0] qn_d [DivLat+1];
  assign x1_d[0] = x1_q; assign y1_d[0] = y1_q;
  assign dx_d[0] = dx_q; assign dy_d[0] = dy_q;
  for (genvar b = 0; b < 4; b++) begin : g_flags
    assign pz_d[0][b] = (p_q[b] == '0);
    assign pn_d[0][b] = p_q[b][DW-1];
    assign qn_d[0][b] = q_q[b][DW-1];
  end
  for (genvar s = 0; s < DivLat; s++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x1_d[s+1] <= x1_d[s]; y1_d[s+1] <= y1_d[s];
        dx_d[s+1] <= dx_d[s]; dy_d[s+1] <= dy_d[s];
        pz_d[s+1] <= pz_d[s]; pn_d[s+1] <= pn_d[s]; qn_d[s+1] <= qn_d[s];
      end
    end
  end

  // four ratio dividers
  logic signed [TW-1:0] t_w [4];
  for (genvar b = 0; b < 4; b++) begin : g_div
    lswc_divider #(.NumW(DW), .FracW(PARAM_FRAC_BITS)) u_div (
      .clk_i, .rst_ni, .adv_i(adv),
      .num_i(q_q[b]), .den_i(p_q[b]), .quot_o(t_w[b])
    );
  end

  // stage a: entry/exit candidates per boundary
  logic signed [TW-1:0] en_a_q [4];
  logic signed [TW-1:0] ex_a_q [4];
  logic rej_a_q;
  logic signed [CW-1:0] x1_a_q, y1_a_q;
  logic signed [DW-1:0] dx_a_q, dy_a_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int b = 0; b < 4; b++) begin
        en_a_q[b] <= (!pz_d[DivLat][b] && pn_d[DivLat][b] && t_w[b] > 0) ? t_w[b] : '0;
        ex_a_q[b] <= (!pz_d[DivLat][b] && !pn_d[DivLat][b] && t_w[b] < OneT)
                     ? t_w[b] : OneT;
      end
      rej_a_q <= |(pz_d[DivLat] & qn_d[DivLat]);
      x1_a_q <= x1_d[DivLat]; y1_a_q <= y1_d[DivLat];
      dx_a_q <= dx_d[DivLat]; dy_a_q <= dy_d[DivLat];
    end
  end

  // stage b: reduce to entry and exit
  logic signed [TW-1:0] en_b_q, ex_b_q;
  logic rej_b_q;
  logic signed [CW-1:0] x1_b_q, y1_b_q;
  logic signed [DW-1:0] dx_b_q, dy_b_q;
  logic signed [TW-1:0] en01, en23, ex01, ex23, en_m, ex_m;
  always_comb begin
    en01 = (en_a_q[0] > en_a_q[1]) ? en_a_q[0] : en_a_q[1];
    en23 = (en_a_q[2] > en_a_q[3]) ? en_a_q[2] : en_a_q[3];
    en_m = (en01 > en23) ? en01 : en23;
    ex01 = (ex_a_q[0] < ex_a_q[1]) ? ex_a_q[0] : ex_a_q[1];
    ex23 = (ex_a_q[2] < ex_a_q[3]) ? ex_a_q[2] : ex_a_q[3];
    ex_m = (ex01 < ex23) ? ex01 : ex23;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      en_b_q <= en_m; ex_b_q <= ex_m;
      rej_b_q <= rej_a_q || (en_m > ex_m);
      x1_b_q <= x1_a_q; y1_b_q <= y1_a_q; dx_b_q <= dx_a_q; dy_b_q <= dy_a_q;
    end
  end

  // stage c: scale differences, drop fraction, add start point
  // a visible word has 0 <= entry <= exit <= 1.0, so the low bits suffice
  logic signed [SW-1:0] en_s, ex_s;
  assign en_s = $signed(en_b_q[SW-1:0]);
  assign ex_s = $signed(ex_b_q[SW-1:0]);

  logic signed [PW-1:0] psx, psy, pex, pey;
  assign psx = PW'(en_s) * PW'(dx_b_q);
  assign psy = PW'(en_s) * PW'(dy_b_q);
  assign pex = PW'(ex_s) * PW'(dx_b_q);
  assign pey = PW'(ex_s) * PW'(dy_b_q);

  logic vis_q;
  logic signed [CW-1:0] csx_q, csy_q, cex_q, cey_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= !rej_b_q;
      csx_q <= rej_b_q ? '0 : CW'(x1_b_q + CW'(psx >>> PARAM_FRAC_BITS));
      csy_q <= rej_b_q ? '0 : CW'(y1_b_q + CW'(psy >>> PARAM_FRAC_BITS));
      cex_q <= rej_b_q ? '0 : CW'(x1_b_q + CW'(pex >>> PARAM_FRAC_BITS));
      cey_q <= rej_b_q ? '0 : CW'(y1_b_q + CW'(pey >>> PARAM_FRAC_BITS));
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign visible_o = vis_q;
  assign clip_start_x_o = csx_q;
  assign clip_start_y_o = csy_q;
  assign clip_end_x_o = cex_q;
  assign clip_end_y_o = cey_q;

  `LSWC_ASSERT(a_stall_only_full, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  `LSWC_ASSERT(a_hold_on_stall, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
  `LSWC_ASSERT(a_reject_zero, clk_i, rst_ni, (out_valid_o && !visible_o) |-> (clip_start_x_o == '0 && clip_end_y_o == '0))
endmodule
